### src/assert_macros.svh
// Assertion macros used by the checker file of the line tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/irc_tok_pkg.sv
// Package with the shared types, codes and constants of the line tokenizer.
package irc_tok_pkg;

  localparam int MaxParamsDef = 255;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [2:0] RolePrefix = 3'd0;
  localparam logic [2:0] RoleCmd    = 3'd1;
  localparam logic [2:0] RoleMiddle = 3'd2;
  localparam logic [2:0] RoleTrail  = 3'd3;
  localparam logic [2:0] RoleSep    = 3'd4;
  localparam logic [2:0] RoleEol    = 3'd5;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] role;
    logic [7:0] param_number;
    logic       opens_field;
    logic       line_end;
    logic       prefix_is_command;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

### src/irc_tok_fifo.sv
// Result queue of four entries that takes up to two results per cycle.
module irc_tok_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  irc_tok_pkg::push_t   push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 stall_i,
  output irc_tok_pkg::res_t    head_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  irc_tok_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && !stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + (PtrW+1)'(push_i.count) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

endmodule

### src/irc_tok_parse.sv
// Line grammar state and byte tagging for one registered input word.
module irc_tok_parse #(
  parameter int MAX_PARAMS = irc_tok_pkg::MaxParamsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  output irc_tok_pkg::push_t push_o
);

  localparam logic [2:0] PhStart   = 3'd0;
  localparam logic [2:0] PhPrefix  = 3'd1;
  localparam logic [2:0] PhSkipCmd = 3'd2;
  localparam logic [2:0] PhCmd     = 3'd3;
  localparam logic [2:0] PhGap     = 3'd4;
  localparam logic [2:0] PhMiddle  = 3'd5;
  localparam logic [2:0] PhTrail   = 3'd6;

  localparam logic [7:0] MaxCnt = 8'(MAX_PARAMS);

  typedef struct packed {
    irc_tok_pkg::res_t res;
    logic [2:0]        phase;
    logic [7:0]        cnt;
  } tag_t;

  function automatic tag_t tag_byte(logic [7:0] b, logic [2:0] ph, logic [7:0] cnt);
    tag_t t;
    logic sp;
    logic colon;
    logic [7:0] bumped;
    sp     = (b == irc_tok_pkg::ChSpace);
    colon  = (b == irc_tok_pkg::ChColon);
    bumped = (cnt < MaxCnt) ? cnt + 8'd1 : cnt;
    t.res.out_byte          = b;
    t.res.role              = irc_tok_pkg::RoleSep;
    t.res.param_number      = '0;
    t.res.opens_field       = 1'b0;
    t.res.line_end          = 1'b0;
    t.res.prefix_is_command = 1'b0;
    t.phase                 = ph;
    t.cnt                   = cnt;
    unique case (ph)
      PhStart: begin
        if (colon) begin
          t.res.role        = irc_tok_pkg::RolePrefix;
          t.res.opens_field = 1'b1;
          t.phase           = PhPrefix;
        end else if (sp) begin
          t.phase = PhSkipCmd;
        end else begin
          t.res.role        = irc_tok_pkg::RoleCmd;
          t.res.opens_field = 1'b1;
          t.phase           = PhCmd;
        end
      end
      PhPrefix: begin
        if (sp) begin
          t.phase = PhSkipCmd;
        end else begin
          t.res.role = irc_tok_pkg::RolePrefix;
        end
      end
      PhSkipCmd: begin
        if (!sp) begin
          t.res.role        = irc_tok_pkg::RoleCmd;
          t.res.opens_field = 1'b1;
          t.phase           = PhCmd;
        end
      end
      PhCmd: begin
        if (sp) begin
          t.phase = PhGap;
        end else begin
          t.res.role = irc_tok_pkg::RoleCmd;
        end
      end
      PhGap: begin
        if (!sp) begin
          t.res.param_number = bumped;
          t.res.opens_field  = 1'b1;
          t.cnt              = bumped;
          if (colon) begin
            t.phase = PhTrail;
          end else begin
            t.res.role = irc_tok_pkg::RoleMiddle;
            t.phase    = PhMiddle;
          end
        end
      end
      PhMiddle: begin
        if (sp) begin
          t.phase = PhGap;
        end else begin
          t.res.role         = irc_tok_pkg::RoleMiddle;
          t.res.param_number = cnt;
        end
      end
      default: begin
        t.res.role         = irc_tok_pkg::RoleTrail;
        t.res.param_number = cnt;
        t.phase            = PhTrail;
      end
    endcase
    return t;
  endfunction

  logic       held_cr_q, held_cr_d;
  logic       nonempty_q, nonempty_d;
  logic [2:0] phase_q, phase_d;
  logic [7:0] cnt_q, cnt_d;
  tag_t       cr_tag, byte_tag;
  logic [2:0] mid_phase;
  logic [7:0] mid_cnt;

  always_comb begin
    cr_tag    = tag_byte(irc_tok_pkg::ChCr, phase_q, cnt_q);
    mid_phase = held_cr_q ? cr_tag.phase : phase_q;
    mid_cnt   = held_cr_q ? cr_tag.cnt : cnt_q;
    byte_tag  = tag_byte(byte_i, mid_phase, mid_cnt);

    held_cr_d  = held_cr_q;
    nonempty_d = nonempty_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;

    push_o.count  = 2'd0;
    push_o.first  = byte_tag.res;
    push_o.second = byte_tag.res;

    if (step_i) begin
      if (byte_i == irc_tok_pkg::ChLf) begin
        push_o.first.out_byte          = '0;
        push_o.first.role              = irc_tok_pkg::RoleEol;
        push_o.first.param_number      = cnt_q;
        push_o.first.opens_field       = 1'b0;
        push_o.first.line_end          = 1'b1;
        push_o.first.prefix_is_command = (phase_q == PhPrefix);
        push_o.count = nonempty_q ? 2'd1 : 2'd0;
        held_cr_d  = 1'b0;
        nonempty_d = 1'b0;
        phase_d    = PhStart;
        cnt_d      = '0;
      end else begin
        if (held_cr_q) begin
          push_o.first = cr_tag.res;
        end
        if (byte_i == irc_tok_pkg::ChCr) begin
          held_cr_d    = 1'b1;
          push_o.count = held_cr_q ? 2'd1 : 2'd0;
          phase_d      = mid_phase;
          cnt_d        = mid_cnt;
          nonempty_d   = nonempty_q | held_cr_q;
        end else begin
          held_cr_d    = 1'b0;
          push_o.count = held_cr_q ? 2'd2 : 2'd1;
          phase_d      = byte_tag.phase;
          cnt_d        = byte_tag.cnt;
          nonempty_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cr_q  <= 1'b0;
      nonempty_q <= 1'b0;
      phase_q    <= PhStart;
      cnt_q      <= '0;
    end else begin
      held_cr_q  <= held_cr_d;
      nonempty_q <= nonempty_d;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

### src/irc_line_tokenizer_core.sv
// Top level of the IRC line tokenizer: input register, parser and result queue.
//
//   channel  | direction | handshake                    | word
//   data     | in        | data_valid_i / data_stall_o  | data_byte_i
//   result   | out       | result_valid_o / result_stall_i | tagged byte fields
//
// One input word is taken per cycle unless data_stall_o is set; it is parsed from the input
// register, and its results can be taken from the next cycle on, one per cycle unless stalled.
// A word that yields two results, a held CR followed by another byte, pushes both into the
// queue at once, and the four-entry result queue absorbs the extra result.
// The input register moves on only while the queue has room for two results.
// Reset clears the grammar state, the input register's valid flag and the queue.
module irc_line_tokenizer_core #(
  parameter int MAX_PARAMS = irc_tok_pkg::MaxParamsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       data_valid_i,
  output logic       data_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       result_valid_o,
  input  logic       result_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] role_o,
  output logic [7:0] param_number_o,
  output logic       opens_field_o,
  output logic       line_end_o,
  output logic       prefix_is_command_o
);

  logic               in_valid_q, in_valid_d;
  logic [7:0]         in_byte_q;
  logic               accept;
  logic               advance;
  logic               room;
  irc_tok_pkg::push_t push;
  irc_tok_pkg::res_t  head;

  assign advance      = in_valid_q && room;
  assign data_stall_o = in_valid_q && !room;
  assign accept       = data_valid_i && !data_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
    end
  end

  irc_tok_parse #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .push_o (push)
  );

  irc_tok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (result_valid_o),
    .stall_i (result_stall_i),
    .head_o  (head)
  );

  assign out_byte_o          = head.out_byte;
  assign role_o              = head.role;
  assign param_number_o      = head.param_number;
  assign opens_field_o       = head.opens_field;
  assign line_end_o          = head.line_end;
  assign prefix_is_command_o = head.prefix_is_command;

endmodule

### src/irc_tok_checker.sv
// Port-level checker for the line tokenizer and its bind to the top level.
`include "assert_macros.svh"

module irc_tok_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       data_valid_i,
  input logic       data_stall_o,
  input logic [7:0] data_byte_i,
  input logic       result_valid_o,
  input logic       result_stall_i,
  input logic [7:0] out_byte_o,
  input logic [2:0] role_o,
  input logic [7:0] param_number_o,
  input logic       opens_field_o,
  input logic       line_end_o,
  input logic       prefix_is_command_o
);

  `ASSERT_CLK(a_result_hold, clk_i, rst_ni, result_valid_o && result_stall_i |=> result_valid_o && $stable(out_byte_o) && $stable(role_o) && $stable(param_number_o), "stalled result word changed")
  `ASSERT_CLK(a_eol_role, clk_i, rst_ni, result_valid_o |-> (line_end_o == (role_o == irc_tok_pkg::RoleEol)), "line end flag and role disagree")
  `ASSERT_CLK(a_eol_word, clk_i, rst_ni, result_valid_o && line_end_o |-> out_byte_o == 8'd0 && !opens_field_o, "end-of-line word carries a byte or opens a field")
  `ASSERT_CLK(a_pic_eol, clk_i, rst_ni, result_valid_o && prefix_is_command_o |-> line_end_o, "prefix-as-command flag outside end of line")
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !result_valid_o && !data_stall_o, "block not idle after reset")

endmodule

bind irc_line_tokenizer_core irc_tok_checker u_irc_tok_checker (.*);

### dv/tb_irc_line_tokenizer_core.sv
// Testbench for the IRC line tokenizer core: directed table, random messages and a tag predictor.
`timescale 1ns / 100ps

module tb_irc_line_tokenizer_core;

  localparam int MaxParams   = irc_tok_pkg::MaxParamsDef;
  localparam int LimitCycles = 400000;
  localparam int TailCycles  = 16;
  localparam int LongHold    = 300;
  localparam int PhaseWords  = 75;
  localparam int CrowdParams = 258;
  localparam int DirLen      = 23;

  typedef enum logic [2:0] {
    PhStart, PhPrefix, PhSkipCmd, PhCmd, PhGap, PhMiddle, PhTrail
  } phase_e;

  typedef struct packed {
    logic [7:0]        word;
    logic              typed;
    irc_tok_pkg::res_t tag;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       data_valid_i;
  logic       data_stall_o;
  logic [7:0] data_byte_i;
  logic       result_valid_o;
  logic       result_stall_i;
  logic [7:0] out_byte_o;
  logic [2:0] role_o;
  logic [7:0] param_number_o;
  logic       opens_field_o;
  logic       line_end_o;
  logic       prefix_is_command_o;

  irc_line_tokenizer_core #(
    .MAX_PARAMS(MaxParams)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .data_valid_i       (data_valid_i),
    .data_stall_o       (data_stall_o),
    .data_byte_i        (data_byte_i),
    .result_valid_o     (result_valid_o),
    .result_stall_i     (result_stall_i),
    .out_byte_o         (out_byte_o),
    .role_o             (role_o),
    .param_number_o     (param_number_o),
    .opens_field_o      (opens_field_o),
    .line_end_o         (line_end_o),
    .prefix_is_command_o(prefix_is_command_o)
  );

  // Directed table; rows with typed set carry the single tag that word must produce.
  dir_row_t dir_tab [DirLen] = '{
    '{irc_tok_pkg::ChLf,    1'b0, '0},
    '{irc_tok_pkg::ChColon, 1'b1,
      '{irc_tok_pkg::ChColon, irc_tok_pkg::RolePrefix, 8'd0, 1'b1, 1'b0, 1'b0}},
    '{8'h6E,                1'b0, '0},
    '{irc_tok_pkg::ChCr,    1'b0, '0},
    '{irc_tok_pkg::ChLf,    1'b1,
      '{8'h00, irc_tok_pkg::RoleEol, 8'd0, 1'b0, 1'b1, 1'b1}},
    '{irc_tok_pkg::ChCr,    1'b0, '0},
    '{irc_tok_pkg::ChLf,    1'b0, '0},
    '{irc_tok_pkg::ChSpace, 1'b1,
      '{irc_tok_pkg::ChSpace, irc_tok_pkg::RoleSep, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'h50,                1'b0, '0},
    '{8'hFF,                1'b0, '0},
    '{irc_tok_pkg::ChSpace, 1'b0, '0},
    '{8'h00,                1'b1,
      '{8'h00, irc_tok_pkg::RoleMiddle, 8'd1, 1'b1, 1'b0, 1'b0}},
    '{irc_tok_pkg::ChCr,    1'b0, '0},
    '{irc_tok_pkg::ChCr,    1'b0, '0},
    '{8'h78,                1'b0, '0},
    '{irc_tok_pkg::ChSpace, 1'b0, '0},
    '{irc_tok_pkg::ChColon, 1'b1,
      '{irc_tok_pkg::ChColon, irc_tok_pkg::RoleSep, 8'd2, 1'b1, 1'b0, 1'b0}},
    '{irc_tok_pkg::ChSpace, 1'b0, '0},
    '{irc_tok_pkg::ChLf,    1'b1,
      '{8'h00, irc_tok_pkg::RoleEol, 8'd2, 1'b0, 1'b1, 1'b0}},
    '{8'h43,                1'b0, '0},
    '{irc_tok_pkg::ChSpace, 1'b0, '0},
    '{irc_tok_pkg::ChColon, 1'b0, '0},
    '{irc_tok_pkg::ChLf,    1'b1,
      '{8'h00, irc_tok_pkg::RoleEol, 8'd1, 1'b0, 1'b1, 1'b0}}
  };

  irc_tok_pkg::res_t pending_tags [$];
  dir_row_t          typed_tag_q  [$];

  phase_e     tok_phase = PhStart;
  logic       cr_held   = 1'b0;
  logic       line_open = 1'b0;
  logic [7:0] param_cnt = 8'd0;

  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int words_sent   = 0;
  int words_in     = 0;
  int results_seen = 0;
  int held_off     = 0;
  int sat_lines    = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic void push_tag(input logic [7:0] b, input logic [2:0] role,
                                   input logic [7:0] pn, input logic opens,
                                   input logic le, input logic pic);
    irc_tok_pkg::res_t r;
    r.out_byte          = b;
    r.role              = role;
    r.param_number      = pn;
    r.opens_field       = opens;
    r.line_end          = le;
    r.prefix_is_command = pic;
    pending_tags.insert(pending_tags.size(), r);
  endfunction

  function automatic logic [7:0] next_param();
    if (param_cnt < MaxParams) param_cnt = param_cnt + 8'd1;
    return param_cnt;
  endfunction

  function automatic void tag_line_byte(input logic [7:0] b);
    logic sp;
    sp = (b == irc_tok_pkg::ChSpace);
    line_open = 1'b1;
    case (tok_phase)
      PhStart: begin
        if (b == irc_tok_pkg::ChColon) begin
          push_tag(b, irc_tok_pkg::RolePrefix, 8'd0, 1'b1, 1'b0, 1'b0);
          tok_phase = PhPrefix;
        end else if (sp) begin
          push_tag(b, irc_tok_pkg::RoleSep, 8'd0, 1'b0, 1'b0, 1'b0);
          tok_phase = PhSkipCmd;
        end else begin
          push_tag(b, irc_tok_pkg::RoleCmd, 8'd0, 1'b1, 1'b0, 1'b0);
          tok_phase = PhCmd;
        end
      end
      PhPrefix: begin
        if (sp) begin
          push_tag(b, irc_tok_pkg::RoleSep, 8'd0, 1'b0, 1'b0, 1'b0);
          tok_phase = PhSkipCmd;
        end else begin
          push_tag(b, irc_tok_pkg::RolePrefix, 8'd0, 1'b0, 1'b0, 1'b0);
        end
      end
      PhSkipCmd: begin
        if (sp) begin
          push_tag(b, irc_tok_pkg::RoleSep, 8'd0, 1'b0, 1'b0, 1'b0);
        end else begin
          push_tag(b, irc_tok_pkg::RoleCmd, 8'd0, 1'b1, 1'b0, 1'b0);
          tok_phase = PhCmd;
        end
      end
      PhCmd: begin
        if (sp) begin
          push_tag(b, irc_tok_pkg::RoleSep, 8'd0, 1'b0, 1'b0, 1'b0);
          tok_phase = PhGap;
        end else begin
          push_tag(b, irc_tok_pkg::RoleCmd, 8'd0, 1'b0, 1'b0, 1'b0);
        end
      end
      PhGap: begin
        if (sp) begin
          push_tag(b, irc_tok_pkg::RoleSep, 8'd0, 1'b0, 1'b0, 1'b0);
        end else if (b == irc_tok_pkg::ChColon) begin
          push_tag(b, irc_tok_pkg::RoleSep, next_param(), 1'b1, 1'b0, 1'b0);
          tok_phase = PhTrail;
        end else begin
          push_tag(b, irc_tok_pkg::RoleMiddle, next_param(), 1'b1, 1'b0, 1'b0);
          tok_phase = PhMiddle;
        end
      end
      PhMiddle: begin
        if (sp) begin
          push_tag(b, irc_tok_pkg::RoleSep, 8'd0, 1'b0, 1'b0, 1'b0);
          tok_phase = PhGap;
        end else begin
          push_tag(b, irc_tok_pkg::RoleMiddle, param_cnt, 1'b0, 1'b0, 1'b0);
        end
      end
      default: begin
        push_tag(b, irc_tok_pkg::RoleTrail, param_cnt, 1'b0, 1'b0, 1'b0);
        tok_phase = PhTrail;
      end
    endcase
  endfunction

  function automatic void tokenize_word(input logic [7:0] b);
    if (b == irc_tok_pkg::ChLf) begin
      cr_held = 1'b0;
      if (line_open) begin
        push_tag(8'h00, irc_tok_pkg::RoleEol, param_cnt, 1'b0, 1'b1, tok_phase == PhPrefix);
        if (param_cnt == MaxParams) sat_lines++;
      end
      line_open = 1'b0;
      tok_phase = PhStart;
      param_cnt = 8'd0;
    end else begin
      if (cr_held) begin
        cr_held = 1'b0;
        tag_line_byte(irc_tok_pkg::ChCr);
      end
      if (b == irc_tok_pkg::ChCr) cr_held = 1'b1;
      else tag_line_byte(b);
    end
  endfunction

  function automatic void flag_mismatch(input string what, input irc_tok_pkg::res_t want,
                                        input irc_tok_pkg::res_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("Mismatch (%s): expected byte %h role %0d param %0d open %b end %b pic %b, got byte %h role %0d param %0d open %b end %b pic %b",
               what, want.out_byte, want.role, want.param_number, want.opens_field,
               want.line_end, want.prefix_is_command, got.out_byte, got.role,
               got.param_number, got.opens_field, got.line_end, got.prefix_is_command);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    dir_row_t          note;
    irc_tok_pkg::res_t got;
    irc_tok_pkg::res_t want;
    int                n0;
    if (rst_ni) begin
      if (data_valid_i && data_stall_o) held_off++;
      if (data_valid_i && !data_stall_o) begin
        note = typed_tag_q.pop_front();
        n0 = pending_tags.size();
        tokenize_word(data_byte_i);
        if (note.typed && pending_tags.size() == n0 + 1) pending_tags[$] = note.tag;
        words_in++;
      end
      if (result_valid_o && !result_stall_i) begin
        got = '{out_byte_o, role_o, param_number_o, opens_field_o, line_end_o,
                prefix_is_command_o};
        results_seen++;
        if (pending_tags.size() == 0) begin
          flag_mismatch("unexpected", '0, got);
        end else begin
          want = pending_tags.pop_front();
          if (got.out_byte !== want.out_byte || got.role !== want.role ||
              got.param_number !== want.param_number ||
              got.opens_field !== want.opens_field || got.line_end !== want.line_end ||
              got.prefix_is_command !== want.prefix_is_command)
            flag_mismatch("field", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall_i <= 1'b1;
    end else begin
      result_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LimitCycles) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic typed,
                           input irc_tok_pkg::res_t tag);
    int       gap;
    dir_row_t row;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      data_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    row = '{b, typed, tag};
    typed_tag_q.insert(typed_tag_q.size(), row);
    data_valid_i <= 1'b1;
    data_byte_i  <= b;
    do @(posedge clk_i); while (data_stall_o);
    words_sent++;
  endtask

  task automatic wait_for_results();
    data_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_tags.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] tok_char(input bit no_colon);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == irc_tok_pkg::ChLf || c == irc_tok_pkg::ChCr || c == irc_tok_pkg::ChSpace ||
           (no_colon && c == irc_tok_pkg::ChColon));
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(99) < 35) begin
      case ($urandom_range(3))
        0: return irc_tok_pkg::ChLf;
        1: return irc_tok_pkg::ChCr;
        2: return irc_tok_pkg::ChSpace;
        default: return irc_tok_pkg::ChColon;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_message();
    logic [7:0] line [$];
    int kind, n, i, j, r;
    kind = $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) line.insert(line.size(), noise_char());
    end else if (kind < 20) begin
      line.insert(line.size(), irc_tok_pkg::ChColon);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) line.insert(line.size(), tok_char(1'b0));
      if ($urandom_range(1)) line.insert(line.size(), irc_tok_pkg::ChCr);
      line.insert(line.size(), irc_tok_pkg::ChLf);
    end else begin
      if ($urandom_range(99) < 30) begin
        line.insert(line.size(), irc_tok_pkg::ChColon);
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) line.insert(line.size(), tok_char(1'b0));
        n = $urandom_range(1, 2);
        for (i = 0; i < n; i++) line.insert(line.size(), irc_tok_pkg::ChSpace);
      end else if ($urandom_range(99) < 10) begin
        n = $urandom_range(1, 2);
        for (i = 0; i < n; i++) line.insert(line.size(), irc_tok_pkg::ChSpace);
      end
      line.insert(line.size(), tok_char(1'b1));
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) line.insert(line.size(), tok_char(1'b0));
      n = ($urandom_range(99) < 10) ? $urandom_range(6, 20) : $urandom_range(0, 5);
      for (i = 0; i < n; i++) begin
        r = $urandom_range(1, 2);
        for (j = 0; j < r; j++) line.insert(line.size(), irc_tok_pkg::ChSpace);
        line.insert(line.size(), tok_char(1'b1));
        r = $urandom_range(0, 4);
        for (j = 0; j < r; j++) line.insert(line.size(), tok_char(1'b0));
      end
      if ($urandom_range(99) < 40) begin
        line.insert(line.size(), irc_tok_pkg::ChSpace);
        line.insert(line.size(), irc_tok_pkg::ChColon);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) begin
          do r = $urandom_range(255); while (r == irc_tok_pkg::ChLf);
          line.insert(line.size(), 8'(r));
        end
      end
      r = $urandom_range(99);
      if (r < 65) begin
        line.insert(line.size(), irc_tok_pkg::ChCr);
        line.insert(line.size(), irc_tok_pkg::ChLf);
      end else if (r < 88) begin
        line.insert(line.size(), irc_tok_pkg::ChLf);
      end else if (r < 94) begin
        line.insert(line.size(), irc_tok_pkg::ChCr);
        line.insert(line.size(), irc_tok_pkg::ChCr);
        line.insert(line.size(), irc_tok_pkg::ChLf);
      end else begin
        line.insert(line.size(), irc_tok_pkg::ChLf);
        line.insert(line.size(), irc_tok_pkg::ChLf);
      end
    end
    foreach (line[k]) send_word(line[k], 1'b0, '0);
  endtask

  task automatic send_crowded_line();
    int i;
    send_word(8'h4D, 1'b0, '0);
    for (i = 0; i < CrowdParams; i++) begin
      send_word(irc_tok_pkg::ChSpace, 1'b0, '0);
      send_word(tok_char(1'b1), 1'b0, '0);
    end
    send_word(irc_tok_pkg::ChSpace, 1'b0, '0);
    send_word(irc_tok_pkg::ChColon, 1'b0, '0);
    send_word(8'h7A, 1'b0, '0);
    send_word(irc_tok_pkg::ChCr, 1'b0, '0);
    send_word(irc_tok_pkg::ChLf, 1'b0, '0);
  endtask

  initial begin
    int ph;
    int start;
    rst_ni         <= 1'b0;
    data_valid_i   <= 1'b0;
    data_byte_i    <= 8'h00;
    result_stall_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirLen; i++) send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].tag);
    wait_for_results();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 61; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      start = words_sent;
      while (words_sent - start < PhaseWords) send_message();
      wait_for_results();
    end

    // The receiver holds off as a line with more parameters than the counter allows starts to
    // stream in, so the result queue fills and the input gets stalled.
    gap_pct   = 0;
    stall_pct = 0;
    hold_req++;
    send_crowded_line();
    wait_for_results();

    gap_pct   = 13;
    stall_pct = 13;
    repeat (3) send_message();
    wait_for_results();

    if (pending_tags.size() != 0) begin
      while (pending_tags.size() != 0) flag_mismatch("missing", pending_tags.pop_front(), '0);
    end

    $display("Summary: %0d words in, %0d tagged results checked, %0d mismatches.",
             words_in, results_seen, err_cnt);
    $display("Input held off for %0d cycles; %0d lines hit the parameter ceiling.",
             held_off, sat_lines);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
